// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helper macros
// shared clocked assertion forms used by the checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, reset gated
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication checked during reset too
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/v2n_pkg.sv
// ---------------------------------------------------------------------------
// v2n_pkg
// shared widths and cell types for the vector normalize pipeline
// ---------------------------------------------------------------------------
package v2n_pkg;
    localparam int CW     = 32;                 // component width
    localparam int SW     = 2 * CW + 1;         // sum of squares width
    localparam int RW     = CW;                 // root width
    localparam int UF     = 30;                 // unit fraction bits
    localparam int UW     = 32;                 // unit output width
    localparam int QB     = UF + 1;             // quotient bits (q <= 2^30)
    localparam int NDIV   = QB;                 // divider cells
    localparam int MW     = 33;                 // magnitude width
    localparam int PW     = SW + QB;            // q * s running product
    localparam int AW     = 2 * CW + 2 * UF + 3; // a^2 * 2^60 remainder
    localparam int TDI_W  = ((2 * CW + 7) / 8) * 8;
    localparam int TDO_W  = ((2 * UW + MW + 7) / 8) * 8;

    // sqrt cell carries sum, root, remainder and side data
    typedef struct packed {
        logic            vld;
        logic            nx;
        logic            ny;
        logic [2*CW-1:0] a2x;
        logic [2*CW-1:0] a2y;
        logic [SW-1:0]   s;
        logic [RW-1:0]   root;
        logic [SW:0]     rem;
        logic [SW-1:0]   sh;   // remaining s bits, consumed two per cell
    } t_sq;

    // divider cell builds the largest q with q^2 * s <= a^2 * 2^60
    // r holds a^2 * 2^60 - q^2 * s, p holds q * s
    typedef struct packed {
        logic              vld;
        logic              zero;
        logic [MW-1:0]     mag;
        logic              nx;
        logic              ny;
        logic [SW-1:0]     s;
        logic [AW-1:0]     rx;
        logic [AW-1:0]     ry;
        logic [PW-1:0]     px;
        logic [PW-1:0]     py;
        logic [QB-1:0]     qx;
        logic [QB-1:0]     qy;
    } t_dv;
endpackage

// File: rtl/core/v2n_sqrt_cell.sv
// ---------------------------------------------------------------------------
// v2n_sqrt_cell
// one bit of the restoring integer square root
// ---------------------------------------------------------------------------
module v2n_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  v2n_pkg::t_sq  i_d,
    output v2n_pkg::t_sq  o_d
);
    import v2n_pkg::*;

    t_sq           r_d;
    t_sq           n_d;
    logic [SW:0]   rem2;
    logic [SW:0]   trial;

    always_comb begin
        n_d   = i_d;
        rem2  = {i_d.rem[SW-2:0], i_d.sh[SW-1:SW-2]};
        trial = (SW+1)'({i_d.root, 2'b01});
        n_d.sh = {i_d.sh[SW-3:0], 2'b00};
        if (rem2 >= trial) begin
            n_d.rem  = rem2 - trial;
            n_d.root = {i_d.root[RW-2:0], 1'b1};
        end else begin
            n_d.rem  = rem2;
            n_d.root = {i_d.root[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

// File: rtl/core/v2n_div_cell.sv
// ---------------------------------------------------------------------------
// v2n_div_cell
// one quotient bit per lane: keeps q if q^2*s <= a^2*2^60
// ---------------------------------------------------------------------------
module v2n_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [4:0]    i_bit,
    input  v2n_pkg::t_dv  i_d,
    output v2n_pkg::t_dv  o_d
);
    import v2n_pkg::*;

    t_dv             r_d;
    t_dv             n_d;
    logic [AW-1:0]   tx;
    logic [AW-1:0]   ty;

    // (q + 2^b)^2 * s - q^2 * s = (q*s << (b+1)) + (s << 2b)
    always_comb begin
        n_d = i_d;
        tx  = (AW'(i_d.px) << (i_bit + 5'd1)) + (AW'(i_d.s) << {i_bit, 1'b0});
        ty  = (AW'(i_d.py) << (i_bit + 5'd1)) + (AW'(i_d.s) << {i_bit, 1'b0});
        if (tx <= i_d.rx) begin
            n_d.rx = i_d.rx - tx;
            n_d.px = i_d.px + (PW'(i_d.s) << i_bit);
            n_d.qx = i_d.qx | (QB'(1) << i_bit);
        end
        if (ty <= i_d.ry) begin
            n_d.ry = i_d.ry - ty;
            n_d.py = i_d.py + (PW'(i_d.s) << i_bit);
            n_d.qy = i_d.qy | (QB'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

// File: rtl/core/vector2_normalize_unit.sv
// pipeline: 65 register stages (square, 32 root cells, 31 quotient cells, output)
// throughput: one vector per cycle unless the row holds; each cell handles one bit of one vector
// the whole row holds while the output register is full and not taken
// reset: synchronous active low, clears all valid bits; no payload clear
// ---------------------------------------------------------------------------
// vector2_normalize_unit
// magnitude and unit vector of a 2d fixed point vector
// ---------------------------------------------------------------------------
module vector2_normalize_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [v2n_pkg::TDI_W-1:0]  s_axis_tdata,   // vec_x, vec_y
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [v2n_pkg::TDO_W-1:0]  m_axis_tdata,   // unit_x, unit_y, magnitude
    output logic                       m_axis_tuser    // zero_vector
);
    import v2n_pkg::*;

    t_sq                     sq [1:RW];
    t_dv                     dv [1:NDIV];
    t_sq                     w_sq0;
    t_sq                     r_sq0;
    t_dv                     w_dv0;
    logic                    w_en;
    logic                    r_ov;
    logic                    r_ou;
    logic [TDO_W-1:0]        r_od;
    logic [CW-1:0]           w_x;
    logic [CW-1:0]           w_y;
    logic signed [2*CW-1:0]  w_px;
    logic signed [2*CW-1:0]  w_py;
    logic [MW-1:0]           w_mag;
    logic [UW-1:0]           w_ux;
    logic [UW-1:0]           w_uy;

    assign w_en          = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_x  = s_axis_tdata[CW-1:0];
    assign w_y  = s_axis_tdata[2*CW-1:CW];
    assign w_px = $signed(w_x) * $signed(w_x);
    assign w_py = $signed(w_y) * $signed(w_y);

    // squares are formed combinationally and registered in r_sq0, ahead of the root row
    always_comb begin
        w_sq0      = '0;
        w_sq0.vld  = s_axis_tvalid && w_en;
        w_sq0.nx   = w_x[CW-1];
        w_sq0.ny   = w_y[CW-1];
        w_sq0.a2x  = w_px;
        w_sq0.a2y  = w_py;
        w_sq0.s    = {1'b0, w_px} + {1'b0, w_py};
        // pad to even bit count: shift register holds s aligned at top
        w_sq0.sh   = w_sq0.s << 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq0.vld <= 1'b0;
        end else if (w_en) begin
            r_sq0 <= w_sq0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < RW; g++) begin : g_sq
            if (g == 0) begin : g_f
                v2n_sqrt_cell u_c (.i_clk, .i_rst_n, .i_en(w_en), .i_d(r_sq0), .o_d(sq[1]));
            end else begin : g_n
                v2n_sqrt_cell u_c (.i_clk, .i_rst_n, .i_en(w_en), .i_d(sq[g]),
                                   .o_d(sq[g+1]));
            end
        end
    endgenerate

    always_comb begin
        w_dv0      = '0;
        w_dv0.vld  = sq[RW].vld;
        w_dv0.zero = (sq[RW].s == '0);
        w_dv0.mag  = MW'(sq[RW].root);
        w_dv0.nx   = sq[RW].nx;
        w_dv0.ny   = sq[RW].ny;
        w_dv0.s    = sq[RW].s;
        w_dv0.rx   = AW'({sq[RW].a2x, {(2*UF){1'b0}}});
        w_dv0.ry   = AW'({sq[RW].a2y, {(2*UF){1'b0}}});
    end

    generate
        for (g = 0; g < NDIV; g++) begin : g_dv
            if (g == 0) begin : g_f
                v2n_div_cell u_c (.i_clk, .i_rst_n, .i_en(w_en), .i_bit(5'(UF - g)),
                                  .i_d(w_dv0), .o_d(dv[1]));
            end else begin : g_n
                v2n_div_cell u_c (.i_clk, .i_rst_n, .i_en(w_en), .i_bit(5'(UF - g)),
                                  .i_d(dv[g]), .o_d(dv[g+1]));
            end
        end
    endgenerate

    assign w_mag = dv[NDIV].mag;
    assign w_ux  = dv[NDIV].zero ? '0 :
                   (dv[NDIV].nx ? (~UW'(dv[NDIV].qx) + UW'(1)) : UW'(dv[NDIV].qx));
    assign w_uy  = dv[NDIV].zero ? '0 :
                   (dv[NDIV].ny ? (~UW'(dv[NDIV].qy) + UW'(1)) : UW'(dv[NDIV].qy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= dv[NDIV].vld;
            r_ou <= dv[NDIV].zero;
            r_od <= {{(TDO_W - 2*UW - MW){1'b0}}, w_mag, w_uy, w_ux};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_ou;
endmodule

// File: rtl/core/v2n_checker.sv
// ---------------------------------------------------------------------------
// v2n_checker
// port level checks for the vector normalize unit
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module v2n_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [v2n_pkg::TDO_W-1:0]  m_axis_tdata,
    input logic                       m_axis_tuser
);
    logic w_stall;

    assign w_stall = m_axis_tvalid && !m_axis_tready;

    `ASSERT_CLK(a_hold, i_clk, i_rst_n, w_stall |=> m_axis_tvalid, "valid dropped")
    `ASSERT_CLK(a_keep, i_clk, i_rst_n, w_stall |=> $stable(m_axis_tdata), "data changed")
    `ASSERT_CLK(a_zero, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0), "zero vector payload")
    `ASSERT_CLK(a_rdy, i_clk, i_rst_n, m_axis_tready |-> s_axis_tready, "ready not passed back")
    `ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
endmodule

bind vector2_normalize_unit v2n_checker u_chk (.*);
